[rtl/core/mmss_pkg.sv]
`default_nettype none
package mmss_pkg;

  localparam int unsigned POS_W   = 30;
  localparam int unsigned COUNT_W = 11;

  localparam logic [POS_W-1:0]   SEARCH_TOP  = POS_W'(1000000000);
  localparam logic [COUNT_W-1:0] PLACE_RESET = COUNT_W'(2);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SHIFT,
    ST_SEARCH,
    ST_PASS
  } state_t;

endpackage
`default_nettype wire

[rtl/core/mmss_greedy.sv]
`default_nettype none
// Greedy feasibility pass: one stall per cycle, compared against the last
// placed stall with a single subtract-and-compare.
module mmss_greedy
  import mmss_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [POS_W-1:0] gap,
  input  wire logic [COUNT_W-1:0] need_init,
  input  wire logic             elem_valid,
  input  wire logic [POS_W-1:0] elem,
  output logic                  busy,
  output logic                  done,
  output logic                  fits
);

  logic               active_r, active_nxt;
  logic               placed_r, placed_nxt;
  logic [POS_W-1:0]   prev_r, prev_nxt;
  logic [COUNT_W-1:0] need_r, need_nxt;
  logic               done_r, done_nxt;
  logic               fits_r, fits_nxt;
  logic [POS_W-1:0]   diff;
  logic               take;

  assign diff = elem - prev_r;
  assign take = !placed_r || (diff >= gap);

  // Advance one stall per cycle; stop on success, at end of store, or at once when no stall is needed
  always_comb begin
    active_nxt = active_r;
    placed_nxt = placed_r;
    prev_nxt   = prev_r;
    need_nxt   = need_r;
    done_nxt   = 1'b0;
    fits_nxt   = fits_r;
    if (start) begin
      placed_nxt = 1'b0;
      need_nxt   = need_init;
      fits_nxt   = 1'b0;
      if (need_init == '0) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end else begin
        active_nxt = 1'b1;
      end
    end else if (active_r) begin
      if (!elem_valid) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end else if (take) begin
        placed_nxt = 1'b1;
        prev_nxt   = elem;
        need_nxt   = need_r - COUNT_W'(1);
        if (need_r == COUNT_W'(1)) begin
          active_nxt = 1'b0;
          done_nxt   = 1'b1;
          fits_nxt   = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      done_r   <= 1'b0;
      fits_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      done_r   <= done_nxt;
      fits_r   <= fits_nxt;
    end
    placed_r <= placed_nxt;
    prev_r   <= prev_nxt;
    need_r   <= need_nxt;
  end

  assign busy = active_r;
  assign done = done_r;
  assign fits = fits_r;

endmodule
`default_nettype wire

[rtl/core/max_min_spacing_search_unit.sv]
`default_nettype none
// Channel | Ports        | Payload
// in      | in_t*        | tdata[29:0] position, tlast last
// out     | out_t*       | tdata[29:0] best_gap, tuser overflow
// cfg     | cfg_we/wdata | place_count (11 bits)
//
// A stored position is sorted in by insertion, moving one larger stored entry
// up per cycle (one memory read/write per cycle); a dropped one only sets overflow.
// A last item then runs up to 30 binary-search steps, each a setup state
// (ST_SEARCH) and a greedy pass (ST_PASS) through one memory read port and
// one compare unit; a final ST_SEARCH visit posts the result.
// Reset is synchronous; no clearing pass. in_tready is low while an item is
// being sorted or searched; a finished search holds while the previous result
// still waits on out_tready.
module max_min_spacing_search_unit
  import mmss_pkg::*;
#(
  parameter int unsigned MAX_STALLS = 1024
) (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [31:0]  in_tdata,   // [29:0] position
  input  wire logic         in_tlast,   // last
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [31:0]       out_tdata,  // [29:0] best_gap
  output logic              out_tuser,  // overflow
  input  wire logic         cfg_we,
  input  wire logic [10:0]  cfg_wdata   // place_count
);

  localparam int unsigned IDX_W = $clog2(MAX_STALLS);
  localparam int unsigned CNT_W = $clog2(MAX_STALLS + 1);

  logic [POS_W-1:0] mem [MAX_STALLS];

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  logic               ovf_r, ovf_nxt;
  logic [COUNT_W-1:0] place_r;
  logic [POS_W-1:0]   lo_r, lo_nxt, hi_r, hi_nxt;
  logic [POS_W-1:0]   newpos_r, newpos_nxt;
  logic               last_r, last_nxt;
  logic [CNT_W-1:0]   j_r, j_nxt;
  logic [CNT_W-1:0]   ridx_r, ridx_nxt;
  logic [POS_W-1:0]   rdata_r;
  logic               rvalid_r, rvalid_nxt;
  logic               res_valid_r, res_valid_nxt;
  logic [POS_W-1:0]   res_gap_r, res_gap_nxt;
  logic               res_ovf_r, res_ovf_nxt;

  logic               we;
  logic [IDX_W-1:0]   waddr;
  logic [POS_W-1:0]   wdata;
  logic [IDX_W-1:0]   raddr;
  logic               g_start, g_busy, g_done, g_fits;
  logic [POS_W:0]     mid_sum;
  logic [POS_W-1:0]   mid;
  logic               accept;

  assign mid_sum = {1'b0, lo_r} + {1'b0, hi_r};
  assign mid     = mid_sum[POS_W:1];
  assign accept  = in_tvalid && in_tready;

  // Memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_LOAD: begin
        if (accept) begin
          if (count_r >= CNT_W'(MAX_STALLS)) state_nxt = in_tlast ? ST_SEARCH : ST_LOAD;
          else state_nxt = ST_SHIFT;
        end
      end
      ST_SHIFT: begin
        if (rvalid_r && !(rdata_r > newpos_r && j_r != '0)) begin
          state_nxt = last_r ? ST_SEARCH : ST_LOAD;
        end else if (!rvalid_r && j_r == '0) begin
          state_nxt = last_r ? ST_SEARCH : ST_LOAD;
        end
      end
      ST_SEARCH: begin
        if ((hi_r - lo_r) > POS_W'(1)) state_nxt = ST_PASS;
        else if (!res_valid_r || out_tready) state_nxt = ST_LOAD;
      end
      ST_PASS:   if (g_done) state_nxt = ST_SEARCH;
      default:   state_nxt = ST_LOAD;
    endcase
  end

  // Datapath and outputs
  always_comb begin
    count_nxt     = count_r;
    ovf_nxt       = ovf_r;
    lo_nxt        = lo_r;
    hi_nxt        = hi_r;
    newpos_nxt    = newpos_r;
    last_nxt      = last_r;
    j_nxt         = j_r;
    ridx_nxt      = ridx_r;
    rvalid_nxt    = 1'b0;
    res_valid_nxt = res_valid_r && !out_tready;
    res_gap_nxt   = res_gap_r;
    res_ovf_nxt   = res_ovf_r;
    we            = 1'b0;
    waddr         = j_r[IDX_W-1:0];
    wdata         = newpos_r;
    raddr         = ridx_r[IDX_W-1:0];
    g_start       = 1'b0;
    in_tready     = 1'b0;
    unique case (state_r)
      ST_LOAD: begin
        in_tready = 1'b1;
        if (accept) begin
          newpos_nxt = in_tdata[POS_W-1:0];
          last_nxt   = in_tlast;
          if (count_r >= CNT_W'(MAX_STALLS)) begin
            ovf_nxt = 1'b1;
          end else begin
            j_nxt = count_r;
            if (count_r != '0) begin
              raddr      = IDX_W'(count_r - CNT_W'(1));
              rvalid_nxt = 1'b1;
            end
          end
          if (in_tlast) begin
            lo_nxt = '0;
            hi_nxt = SEARCH_TOP;
          end
        end
      end
      ST_SHIFT: begin
        // Move one larger entry up per cycle, else drop the new one in
        if (rvalid_r && rdata_r > newpos_r) begin
          we    = 1'b1;
          wdata = rdata_r;
          j_nxt = j_r - CNT_W'(1);
          if (j_r > CNT_W'(1)) begin
            raddr      = IDX_W'(j_r - CNT_W'(2));
            rvalid_nxt = 1'b1;
          end
        end else begin
          we        = 1'b1;
          count_nxt = count_r + CNT_W'(1);
          if (last_r) begin
            lo_nxt = '0;
            hi_nxt = SEARCH_TOP;
          end
        end
      end
      ST_SEARCH: begin
        // Start a pass if the range is open; else hold the result till the output is free
        if ((hi_r - lo_r) > POS_W'(1)) begin
          g_start    = 1'b1;
          raddr      = '0;
          ridx_nxt   = CNT_W'(1);
          rvalid_nxt = count_r != '0;
        end else if (!res_valid_r || out_tready) begin
          res_valid_nxt = 1'b1;
          res_gap_nxt   = lo_r;
          res_ovf_nxt   = ovf_r;
          count_nxt     = '0;
          ovf_nxt       = 1'b0;
        end
      end
      ST_PASS: begin
        // Stream the store through the greedy unit and narrow the search range when it is done
        raddr = ridx_r[IDX_W-1:0];
        if (g_busy || !g_done) begin
          ridx_nxt   = ridx_r + CNT_W'(1);
          rvalid_nxt = ridx_r < count_r;
        end
        if (g_done) begin
          if (g_fits) lo_nxt = mid;
          else hi_nxt = mid;
        end
      end
      default: ;
    endcase
  end

  mmss_greedy u_greedy (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (g_start),
    .gap        (mid),
    .need_init  (place_r),
    .elem_valid (rvalid_r),
    .elem       (rdata_r),
    .busy       (g_busy),
    .done       (g_done),
    .fits       (g_fits)
  );

  // Registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_LOAD;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      lo_r        <= '0;
      hi_r        <= SEARCH_TOP;
      res_valid_r <= 1'b0;
      rvalid_r    <= 1'b0;
      place_r     <= PLACE_RESET;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      ovf_r       <= ovf_nxt;
      lo_r        <= lo_nxt;
      hi_r        <= hi_nxt;
      res_valid_r <= res_valid_nxt;
      rvalid_r    <= rvalid_nxt;
      if (cfg_we) place_r <= cfg_wdata;
    end
    newpos_r  <= newpos_nxt;
    last_r    <= last_nxt;
    j_r       <= j_nxt;
    ridx_r    <= ridx_nxt;
    res_gap_r <= res_gap_nxt;
    res_ovf_r <= res_ovf_nxt;
  end

  assign out_tvalid = res_valid_r;
  assign out_tdata  = {2'b00, res_gap_r};
  assign out_tuser  = res_ovf_r;

endmodule
`default_nettype wire
